// File: rtl/core/wmxh_pkg.sv
// wmxh_pkg: shared constants and types for the word multiply-xor hash unit.
// No dependencies.
`default_nettype none

package wmxh_pkg;

   localparam int unsigned WordWidth  = 64;
   localparam int unsigned HalfWidth  = WordWidth / 2;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned LenWidth   = 8;
   localparam int unsigned WordBytes  = WordWidth / 8;

   localparam logic [WordWidth-1:0]  HashSeed  = 64'd2166136261;
   localparam logic [WordWidth-1:0]  WordMult  = 64'hbf58476d1ce4e5b9;
   localparam logic [WordWidth-1:0]  TailMult  = 64'hd6e8feb86659fd93;
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(WordBytes);

   typedef enum logic [1:0] {
      MIX_SKIP,
      MIX_WORD,
      MIX_TAIL
   } mix_mode_type;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      mix_mode_type         mode;
      logic [WordWidth-1:0] operand;
   } mix_op_type;

endpackage

`default_nettype wire

// File: rtl/core/wmxh_front.sv
// wmxh_front: input register stage; clamps the byte count, tracks the message
// length and builds the mix operand. Depends on wmxh_pkg.
`default_nettype none

module wmxh_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [wmxh_pkg::WordWidth-1:0]   req_data_word,
   input  logic [wmxh_pkg::CountWidth-1:0]  req_byte_count,
   input  logic                             req_last_word,
   input  logic                             advance,
   output wmxh_pkg::mix_op_type             op
);
   import wmxh_pkg::*;

   logic                  load;
   logic [CountWidth-1:0] count_eff;
   logic [LenWidth-1:0]   len_ff;
   logic [LenWidth-1:0]   len_in;
   logic [WordWidth-1:0]  kept;
   mix_op_type            op_ff;
   mix_op_type            op_in;

   always_comb begin
      load      = !op_ff.valid || advance;
      req_stall = !load;
      count_eff = req_byte_count[CountWidth-1] ? FullCount : req_byte_count;
      len_in    = len_ff + LenWidth'(count_eff);
      for (int i = 0; i < WordBytes; i++) begin
         kept[i*8 +: 8] = (CountWidth'(i) < count_eff) ? req_data_word[i*8 +: 8] : 8'h00;
      end
      op_in.valid = req_valid;
      op_in.last  = req_last_word;
      if (count_eff == FullCount) begin
         op_in.mode    = MIX_WORD;
         op_in.operand = req_data_word;
      end else if (count_eff == '0) begin
         op_in.mode    = MIX_SKIP;
         op_in.operand = '0;
      end else begin
         // tail: valid bytes moved up one byte, length low byte underneath
         op_in.mode    = MIX_TAIL;
         op_in.operand = {kept[WordWidth-LenWidth-1:0], len_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.valid <= 1'b0;
      end else if (load) begin
         op_ff <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (load && req_valid) begin
         len_ff <= req_last_word ? '0 : len_in;
      end
   end

   assign op = op_ff;

endmodule

`default_nettype wire

// File: rtl/core/wmxh_mix.sv
// wmxh_mix: running hash register with the xor and 64-bit low-half multiply.
// Depends on wmxh_pkg.
`default_nettype none

module wmxh_mix (
   input  logic                           clock,
   input  logic                           reset,
   input  wmxh_pkg::mix_op_type           op,
   input  logic                           advance,
   output logic [wmxh_pkg::WordWidth-1:0] hash_next
);
   import wmxh_pkg::*;

   logic [WordWidth-1:0] hash_ff;
   logic [WordWidth-1:0] mixed;
   logic [WordWidth-1:0] mult;
   logic [WordWidth-1:0] lo_prod;
   logic [HalfWidth-1:0] cross_sum;
   logic [WordWidth-1:0] product;

   always_comb begin
      mixed   = hash_ff ^ op.operand;
      mult    = (op.mode == MIX_TAIL) ? TailMult : WordMult;
      // low 64 bits of the product from three 32x32 partial products
      lo_prod = WordWidth'(mixed[HalfWidth-1:0]) * WordWidth'(mult[HalfWidth-1:0]);
      cross_sum = HalfWidth'(mixed[WordWidth-1:HalfWidth] * mult[HalfWidth-1:0])
                + HalfWidth'(mixed[HalfWidth-1:0] * mult[WordWidth-1:HalfWidth]);
      product = lo_prod + {cross_sum, {HalfWidth{1'b0}}};
      case (op.mode)
         MIX_WORD, MIX_TAIL: begin
            hash_next = product;
         end
         default: begin
            hash_next = hash_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HashSeed;
      end else if (advance) begin
         hash_ff <= op.last ? HashSeed : hash_next;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/word_multiply_xor_hash64_unit.sv
// word_multiply_xor_hash64_unit: top level of the word multiply-xor hash.
// Depends on wmxh_pkg, wmxh_front and wmxh_mix.
//
// Hashes a message given as little-endian 64-bit words, one word per transfer,
// and returns hash ^ (hash >> 32) after the last word. A word is taken every
// cycle unless the input stalls; the last word passes the operand register and
// then the result register. The rate is set by the combinational xor and 64-bit
// multiply that closes the running-hash loop. The input side stalls only while
// a finished result waits on a stalled output and the next last word is queued.
`default_nettype none

module word_multiply_xor_hash64_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [wmxh_pkg::WordWidth-1:0]  req_data_word,
   input  logic [wmxh_pkg::CountWidth-1:0] req_byte_count,
   input  logic                            req_last_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [wmxh_pkg::WordWidth-1:0]  rsp_hash_value
);
   import wmxh_pkg::*;

   mix_op_type           op;
   logic                 advance;
   logic [WordWidth-1:0] hash_next;
   logic                 rsp_valid_ff;
   logic [WordWidth-1:0] rsp_ff;

   wmxh_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .advance        (advance),
      .op             (op)
   );

   wmxh_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .advance   (advance),
      .hash_next (hash_next)
   );

   assign advance = op.valid && (!op.last || !rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && op.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && op.last) begin
         rsp_ff <= hash_next;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_ff ^ {{HalfWidth{1'b0}}, rsp_ff[WordWidth-1:HalfWidth]};

endmodule

`default_nettype wire

// File: rtl/core/wmxh_checker.sv
// wmxh_checker: port-level assertions for word_multiply_xor_hash64_unit,
// bound to the top level. Depends on wmxh_pkg.
`default_nettype none

module wmxh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [wmxh_pkg::WordWidth-1:0]  req_data_word,
   input logic [wmxh_pkg::CountWidth-1:0] req_byte_count,
   input logic                            req_last_word,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [wmxh_pkg::WordWidth-1:0]  rsp_hash_value
);
   import wmxh_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output is free");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_word, 2))
      else $error("result without a last-word transfer");

endmodule

bind word_multiply_xor_hash64_unit wmxh_checker u_wmxh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_data_word  (req_data_word),
   .req_byte_count (req_byte_count),
   .req_last_word  (req_last_word),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash_value (rsp_hash_value)
);

`default_nettype wire

// File: test/word_multiply_xor_hash64_checker.sv
// word_multiply_xor_hash64_checker: watches both channels of the hash unit,
// predicts each message hash and compares it with the returned transfer.
// Depends on wmxh_pkg for the port widths only.
`default_nettype none

module word_multiply_xor_hash64_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [wmxh_pkg::WordWidth-1:0]  req_data_word,
   input  logic [wmxh_pkg::CountWidth-1:0] req_byte_count,
   input  logic                            req_last_word,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [wmxh_pkg::WordWidth-1:0]  rsp_hash_value,
   output int unsigned                     mismatch_count,
   output int unsigned                     hashes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] SeedValue  = 64'd2166136261;
   localparam logic [63:0] WordFactor = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] TailFactor = 64'hd6e8feb86659fd93;
   localparam logic [3:0]  WordBytes  = 4'd8;
   localparam int unsigned ReportMax  = 10;

   logic [63:0] model_hash;
   logic [7:0]  model_length;
   logic [63:0] digests_due[$];
   logic [63:0] digest_want;
   int unsigned bad_total = 0;

   initial begin
      mismatch_count = 0;
      hashes_pending = 0;
   end

   task automatic absorb_word(input logic [63:0] word, input logic [3:0] count_in,
                              input logic last);
      logic [3:0]  count;
      logic [63:0] mask;
      logic [63:0] tail;
      count = (count_in > WordBytes) ? WordBytes : count_in;
      model_length = model_length + {4'd0, count};
      if (count == WordBytes) begin
         model_hash = (model_hash ^ word) * WordFactor;
      end else if (count != 4'd0) begin
         mask = (64'd1 << (count * 8)) - 64'd1;
         tail = ((word & mask) << 8) | {56'd0, model_length};
         model_hash = (model_hash ^ tail) * TailFactor;
      end
      if (last) begin
         digests_due.push_back(model_hash ^ (model_hash >> 32));
         model_hash = SeedValue;
         model_length = 8'd0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         model_hash = SeedValue;
         model_length = 8'd0;
         digests_due.delete();
      end else begin
         // result first: a transfer at this edge belongs to an earlier message
         if (rsp_valid && !rsp_stall) begin
            if (digests_due.size() == 0) begin
               bad_total++;
               if (bad_total <= ReportMax)
                  $display("unexpected hash %h with nothing pending", rsp_hash_value);
            end else begin
               digest_want = digests_due.pop_front();
               if (rsp_hash_value !== digest_want) begin
                  bad_total++;
                  if (bad_total <= ReportMax)
                     $display("hash mismatch: expected %h got %h",
                              digest_want, rsp_hash_value);
               end
            end
         end
         if (req_valid && !req_stall)
            absorb_word(req_data_word, req_byte_count, req_last_word);
      end
      mismatch_count <= bad_total;
      hashes_pending <= digests_due.size();
   end

endmodule

`default_nettype wire

// File: test/word_multiply_xor_hash64_unit_tb.sv
// word_multiply_xor_hash64_unit_tb: drives messages of random words into the
// hash unit with bursty input and a stalling receiver, and gives the verdict.
// Depends on wmxh_pkg, word_multiply_xor_hash64_unit and the hash checker.
`default_nettype none

module word_multiply_xor_hash64_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ItemGoal   = 600;
   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned HoldCycles = 300;
   localparam int unsigned DrainWait  = 10;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [wmxh_pkg::WordWidth-1:0]  req_data_word;
   logic [wmxh_pkg::CountWidth-1:0] req_byte_count;
   logic                            req_last_word;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [wmxh_pkg::WordWidth-1:0]  rsp_hash_value;

   int unsigned mismatch_count;
   int unsigned hashes_pending;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned gap_len;
   int unsigned stall_phase_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic        hold_off_go = 1'b0;
   logic        hold_off_done = 1'b0;
   int unsigned msg_kind;
   int unsigned msg_words;

   word_multiply_xor_hash64_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   word_multiply_xor_hash64_checker hash_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value),
      .mismatch_count (mismatch_count),
      .hashes_pending (hashes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 15))
         0:       random_word = '1;
         1:       random_word = '0;
         default: random_word = {$urandom, $urandom};
      endcase
   endfunction

   // one transfer; valid stays high across items inside a burst
   task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                            input logic last);
      if (burst_left == 0) begin
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap_len != 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= count;
      req_last_word  <= last;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (count != 4'd0 || last)
         items_sent++;
   endtask

   task automatic send_message(input int unsigned full_words);
      for (int unsigned i = 0; i < full_words; i++) begin
         case ($urandom_range(0, 19))
            0:       send_word(random_word(), 4'd0, 1'b0);
            1:       send_word(random_word(), 4'($urandom_range(1, 7)), 1'b0);
            2:       send_word(random_word(), 4'($urandom_range(9, 15)), 1'b0);
            default: send_word(random_word(), 4'd8, 1'b0);
         endcase
      end
      if ($urandom_range(0, 9) == 0)
         send_word(random_word(), 4'($urandom_range(9, 15)), 1'b1);
      else
         send_word(random_word(), 4'($urandom_range(0, 8)), 1'b1);
   endtask

   // receiver: stall pattern changes phase by phase, one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            if (stall_phase_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               stall_phase_left = $urandom_range(20, 120);
            end
            stall_phase_left--;
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_word  = '0;
      req_byte_count = '0;
      req_last_word  = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(random_word(), 4'd0, 1'b1);
      send_word('1, 4'd8, 1'b1);
      send_word('0, 4'd8, 1'b1);
      send_word(64'haaaaaaaaaaaaaaaa, 4'd8, 1'b0);
      send_word('1, 4'd1, 1'b1);
      send_word({$urandom, $urandom}, 4'd7, 1'b1);
      send_word({$urandom, $urandom}, 4'd15, 1'b1);
      send_word({$urandom, $urandom}, 4'd9, 1'b0);
      send_word({$urandom, $urandom}, 4'd0, 1'b1);
      send_word({$urandom, $urandom}, 4'd0, 1'b0);
      send_word({$urandom, $urandom}, 4'd3, 1'b1);
      send_word({$urandom, $urandom}, 4'd5, 1'b0);
      send_word(64'h5555555555555555, 4'd8, 1'b0);
      send_word({$urandom, $urandom}, 4'd2, 1'b1);
      send_word({$urandom, $urandom}, 4'd12, 1'b0);
      send_word({$urandom, $urandom}, 4'd4, 1'b0);
      send_word({$urandom, $urandom}, 4'd6, 1'b1);
      send_word({$urandom, $urandom}, 4'd10, 1'b0);
      send_word({$urandom, $urandom}, 4'd11, 1'b0);
      send_word({$urandom, $urandom}, 4'd13, 1'b0);
      send_word({$urandom, $urandom}, 4'd14, 1'b1);

      while (items_sent < ItemGoal) begin
         if (!hold_off_go && items_sent > 200)
            hold_off_go <= 1'b1;
         msg_kind = $urandom_range(0, 99);
         if (msg_kind < 6)
            msg_words = $urandom_range(31, 40);
         else if (msg_kind < 45)
            msg_words = $urandom_range(0, 2);
         else
            msg_words = $urandom_range(0, 8);
         send_message(msg_words);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (hashes_pending != 0);
      repeat (DrainWait) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
